// ===== hw/rtl/dttf_pkg.sv =====
// Shared types, character codes and fraction weight table for the decimal text parser.
package dttf_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Largest magnitude (2^63 - 1)
  localparam logic [62:0] MAG_MAX = '1;

  // Weight table index at which the weight has decayed to zero
  localparam logic [3:0] WEIGHT_ZERO_IDX = 4'd9;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  // Decoded character class
  typedef struct packed {
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_point;
    logic       is_digit;
    logic       allowed;
    logic [3:0] digit;
  } char_class_t;

  // Parser state as it stands after the current character
  typedef struct packed {
    logic [62:0] mag;
    logic        neg;
    logic        bad;
    logic        sat;
  } parse_result_t;

  // Q0.32 weight of the n-th fraction digit: starts at 0.1, then (w + 5) / 10 per digit
  function automatic logic [31:0] frac_weight(input logic [3:0] idx);
    logic [31:0] w;
    begin
      case (idx)
        4'd0:    w = 32'd429496730;
        4'd1:    w = 32'd42949673;
        4'd2:    w = 32'd4294967;
        4'd3:    w = 32'd429497;
        4'd4:    w = 32'd42950;
        4'd5:    w = 32'd4295;
        4'd6:    w = 32'd430;
        4'd7:    w = 32'd43;
        4'd8:    w = 32'd4;
        default: w = 32'd0;
      endcase
      return w;
    end
  endfunction

endpackage

// ===== hw/rtl/dttf_classify.sv =====
// Character decoder: whitespace, sign, point, digit and allowed-set detection.
module dttf_classify (
  input  logic [7:0]           character,
  output dttf_pkg::char_class_t cls
);

  logic [7:0] digit_off;

  assign digit_off = character - dttf_pkg::CH_ZERO;

  // Class flags
  always_comb begin
    cls.is_space = ((character >= dttf_pkg::CH_TAB) && (character <= dttf_pkg::CH_CR)) ||
                   (character == dttf_pkg::CH_SPACE);
    cls.is_minus = (character == dttf_pkg::CH_MINUS);
    cls.is_sign  = (character == dttf_pkg::CH_PLUS) || cls.is_minus;
    cls.is_point = (character == dttf_pkg::CH_POINT);
    cls.is_digit = (character >= dttf_pkg::CH_ZERO) && (character <= dttf_pkg::CH_NINE);
    cls.allowed  = cls.is_space || cls.is_sign || cls.is_point || cls.is_digit;
    cls.digit    = digit_off[3:0];
  end

endmodule

// ===== hw/rtl/dttf_parse.sv =====
// Parser state and per-character accumulate step (integer and fraction digits, saturation).
module dttf_parse #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    last,
  input  dttf_pkg::char_class_t   cls,
  output dttf_pkg::parse_result_t res
);

  localparam int          SHIFT = 32 - FRACTION_BITS;
  localparam logic [36:0] HALF  = (37'd1 << SHIFT) >> 1;

  dttf_pkg::phase_t phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [62:0]      mag_r, mag_nxt;
  logic [3:0]       widx_r, widx_nxt;
  logic             bad_r, bad_nxt;
  logic             sat_r, sat_nxt;

  logic             do_int;
  logic             do_frac;
  logic [66:0]      int_wide;
  logic             int_ovf;
  logic [31:0]      weight;
  logic [35:0]      frac_prod;
  logic [36:0]      frac_term;
  logic [63:0]      frac_sum;
  logic             frac_ovf;

  // Integer digit: mag*10 + d*2^FRACTION_BITS, checked against the top
  assign int_wide = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} +
                    (67'(cls.digit) << FRACTION_BITS);
  assign int_ovf  = |int_wide[66:63];

  // Fraction digit: d*weight rounded half up to FRACTION_BITS
  assign weight    = dttf_pkg::frac_weight(widx_r);
  assign frac_prod = 36'(cls.digit) * 36'(weight);
  assign frac_term = ({1'b0, frac_prod} + HALF) >> SHIFT;
  assign frac_sum  = {1'b0, mag_r} + 64'(frac_term);
  assign frac_ovf  = frac_sum[63];

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    widx_nxt  = widx_r;
    sat_nxt   = sat_r;
    bad_nxt   = bad_r | ~cls.allowed;
    do_int    = 1'b0;
    do_frac   = 1'b0;

    case (phase_r)
      dttf_pkg::PH_SPACE: begin
        if (cls.is_space) begin
          phase_nxt = dttf_pkg::PH_SPACE;
        end else if (cls.is_sign) begin
          neg_nxt   = cls.is_minus;
          phase_nxt = dttf_pkg::PH_INT;
        end else if (cls.is_digit) begin
          do_int    = 1'b1;
          phase_nxt = dttf_pkg::PH_INT;
        end else if (cls.is_point) begin
          phase_nxt = dttf_pkg::PH_FRAC;
        end else begin
          phase_nxt = dttf_pkg::PH_STOP;
        end
      end
      dttf_pkg::PH_INT: begin
        if (cls.is_digit) begin
          do_int = 1'b1;
        end else if (cls.is_point) begin
          phase_nxt = dttf_pkg::PH_FRAC;
        end else begin
          phase_nxt = dttf_pkg::PH_STOP;
        end
      end
      dttf_pkg::PH_FRAC: begin
        if (cls.is_digit) begin
          do_frac = 1'b1;
        end else begin
          phase_nxt = dttf_pkg::PH_STOP;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // Integer accumulate with saturation
    if (do_int && !sat_r) begin
      if (int_ovf) begin
        mag_nxt = dttf_pkg::MAG_MAX;
        sat_nxt = 1'b1;
      end else begin
        mag_nxt = int_wide[62:0];
      end
    end

    // Fraction accumulate; the weight decays even once saturated
    if (do_frac) begin
      if (widx_r != dttf_pkg::WEIGHT_ZERO_IDX) begin
        widx_nxt = widx_r + 4'd1;
      end
      if (!sat_r) begin
        if (frac_ovf) begin
          mag_nxt = dttf_pkg::MAG_MAX;
          sat_nxt = 1'b1;
        end else begin
          mag_nxt = frac_sum[62:0];
        end
      end
    end
  end

  assign res.mag = mag_nxt;
  assign res.neg = neg_nxt;
  assign res.bad = bad_nxt;
  assign res.sat = sat_nxt;

  // State registers; the last character of a string returns to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dttf_pkg::PH_SPACE;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      widx_r  <= '0;
      bad_r   <= 1'b0;
      sat_r   <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase_r <= dttf_pkg::PH_SPACE;
        neg_r   <= 1'b0;
        mag_r   <= '0;
        widx_r  <= '0;
        bad_r   <= 1'b0;
        sat_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        mag_r   <= mag_nxt;
        widx_r  <= widx_nxt;
        bad_r   <= bad_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

  // Saturation pins the magnitude at its maximum
  a_sat_pins_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (mag_r == dttf_pkg::MAG_MAX))
    else $error("saturated without maximum magnitude");

  // A string end clears the accumulated state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> (phase_r == dttf_pkg::PH_SPACE) && (mag_r == '0) && !bad_r && !sat_r)
    else $error("state not cleared after last character");

  // The weight index never runs past the zero entry
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= dttf_pkg::WEIGHT_ZERO_IDX)
    else $error("weight index out of range");

endmodule

// ===== hw/rtl/decimal_text_to_fixed_point.sv =====
// Top level: decimal text stream in, signed fixed-point number out.
//
// Usage:
//   The input channel (in_tvalid/in_tready/in_tdata/in_tlast) carries one
//   character per beat; in_tlast marks the final character of a string.
//   Leading whitespace, one sign, integer digits, a point and fraction digits
//   are parsed; the first unexpected character stops parsing.
//   The result channel (out_tvalid/out_tready/out_tdata/out_tuser) carries
//   one beat per string: the value as two's complement with FRACTION_BITS
//   fraction bits, an invalid flag and an overflow (saturation) flag.
//   Throughput: one character per cycle while no last character waits for
//   the result register; the accumulate step (multiply by ten, add,
//   saturate compare) in dttf_parse is combinational. out_tvalid rises once
//   the last character has left the input register for the result register.
//   Reset clears the parser to the leading whitespace phase and empties both
//   registers. When the receiver stalls, characters other than the last of a
//   string keep flowing; a last character waits in the input register until
//   the result register is free, and in_tready drops only then.
module decimal_text_to_fixed_point #(
  parameter int FRACTION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input characters
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  // Parsed results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [1:0]  out_tuser   // [0] invalid, [1] overflow
);

  logic                    s1_valid_r, s1_valid_nxt;
  logic [7:0]              s1_char_r;
  logic                    s1_last_r;
  logic                    s1_adv;
  logic                    in_beat;
  logic                    out_free;

  logic                    out_valid_r, out_valid_nxt;
  logic [62:0]             out_mag_r;
  logic                    out_neg_r;
  logic                    out_bad_r;
  logic                    out_sat_r;

  dttf_pkg::char_class_t   cls;
  dttf_pkg::parse_result_t res;

  // Flow control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_beat ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_adv && s1_last_r) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  dttf_classify u_classify (
    .character (s1_char_r),
    .cls       (cls)
  );

  dttf_parse #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .last  (s1_last_r),
    .cls   (cls),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_mag_r <= res.mag;
      out_neg_r <= res.neg;
      out_bad_r <= res.bad;
      out_sat_r <= res.sat;
    end
  end

  // Apply the sign; a negative zero comes out as zero
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_neg_r ? (64'd0 - {1'b0, out_mag_r}) : {1'b0, out_mag_r};
  assign out_tuser  = {out_sat_r, out_bad_r};

  // A result appears only from a last character leaving the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result without a last character");

  // A last character waits while the result register is blocked
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !out_free) |=> (s1_valid_r && s1_last_r && $stable(s1_char_r)))
    else $error("last character lost during stall");

  // A full, stalled result register is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !s1_adv || !s1_last_r)
    else $error("result overwritten while stalled");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for decimal_text_to_fixed_point: text stream in, Q31.32 numbers out.
`timescale 1ns / 1ps

module tb;

  localparam int FRAC_BITS = 32;
  localparam int RUN_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] MAG_LIMIT = {1'b0, dttf_pkg::MAG_MAX};
  localparam logic [31:0] TENTH_Q32 = 32'd429496730;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TOP = 8'hFF;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [63:0] value;
    logic        invalid;
    logic        overflow;
  } parse_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shared bench state
  parse_out_t pending_numbers[$];
  int         chars_sent;
  int         mismatches;
  int         cycle_count;
  bit         gaps_on;
  bit         stall_on;
  bit         hold_req;

  // Predicted parser state
  dttf_pkg::phase_t ps_phase;
  logic             ps_neg;
  logic [63:0]      ps_mag;
  logic [31:0]      ps_weight;
  logic             ps_bad;
  logic             ps_sat;

  decimal_text_to_fixed_point #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] c);
    return (c >= dttf_pkg::CH_TAB && c <= dttf_pkg::CH_CR) || c == dttf_pkg::CH_SPACE;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= dttf_pkg::CH_ZERO && c <= dttf_pkg::CH_NINE;
  endfunction

  function automatic void clear_parser();
    ps_phase  = dttf_pkg::PH_SPACE;
    ps_neg    = 1'b0;
    ps_mag    = '0;
    ps_weight = TENTH_Q32;
    ps_bad    = 1'b0;
    ps_sat    = 1'b0;
  endfunction

  function automatic void take_int_digit(input logic [3:0] d);
    logic [63:0] add;
    add = 64'(d) << FRAC_BITS;
    if (!ps_sat) begin
      if (ps_mag > (MAG_LIMIT - add) / 64'd10) begin
        ps_mag = MAG_LIMIT;
        ps_sat = 1'b1;
      end else begin
        ps_mag = ps_mag * 64'd10 + add;
      end
    end
  endfunction

  function automatic void take_frac_digit(input logic [3:0] d);
    int          sh;
    logic [63:0] half;
    logic [63:0] term;
    sh   = 32 - FRAC_BITS;
    half = (sh == 0) ? 64'd0 : (64'd1 << (sh - 1));
    term = (64'(d) * 64'(ps_weight) + half) >> sh;
    ps_weight = 32'((64'(ps_weight) + 64'd5) / 64'd10);
    if (!ps_sat) begin
      if (ps_mag > MAG_LIMIT - term) begin
        ps_mag = MAG_LIMIT;
        ps_sat = 1'b1;
      end else begin
        ps_mag = ps_mag + term;
      end
    end
  endfunction

  // Advance the predicted parser by one character; 1 when a number is due
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output parse_out_t res);
    logic [3:0] d;
    d = 4'(c - dttf_pkg::CH_ZERO);
    res = '0;
    if (!(is_blank(c) || is_num(c) || c == dttf_pkg::CH_PLUS || c == dttf_pkg::CH_MINUS ||
          c == dttf_pkg::CH_POINT))
      ps_bad = 1'b1;
    case (ps_phase)
      dttf_pkg::PH_SPACE: begin
        if (c == dttf_pkg::CH_PLUS || c == dttf_pkg::CH_MINUS) begin
          ps_neg   = (c == dttf_pkg::CH_MINUS);
          ps_phase = dttf_pkg::PH_INT;
        end else if (is_num(c)) begin
          take_int_digit(d);
          ps_phase = dttf_pkg::PH_INT;
        end else if (c == dttf_pkg::CH_POINT) begin
          ps_phase = dttf_pkg::PH_FRAC;
        end else if (!is_blank(c)) begin
          ps_phase = dttf_pkg::PH_STOP;
        end
      end
      dttf_pkg::PH_INT: begin
        if (is_num(c)) take_int_digit(d);
        else if (c == dttf_pkg::CH_POINT) ps_phase = dttf_pkg::PH_FRAC;
        else ps_phase = dttf_pkg::PH_STOP;
      end
      dttf_pkg::PH_FRAC: begin
        if (is_num(c)) take_frac_digit(d);
        else ps_phase = dttf_pkg::PH_STOP;
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    res.value    = ps_neg ? 64'd0 - ps_mag : ps_mag;
    res.invalid  = ps_bad;
    res.overflow = ps_sat;
    clear_parser();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last);
    int         gap;
    parse_out_t res;
    gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (parse_char(c, last, res)) pending_numbers.push_back(res);
    chars_sent++;
  endtask

  task automatic send_text(input text_t txt);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  // Random well-formed number; near_limit builds one close to the saturation point
  task automatic send_number(input int max_int, input int max_frac, input bit near_limit);
    text_t txt;
    int    r;
    string lead;
    txt  = {};
    lead = "214748364";
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 5);
        txt.push_back(r == 5 ? dttf_pkg::CH_SPACE : dttf_pkg::CH_TAB + 8'(r));
      end
    end
    r = $urandom_range(0, 3);
    if (r == 0) txt.push_back(dttf_pkg::CH_PLUS);
    else if (r == 1) txt.push_back(dttf_pkg::CH_MINUS);
    if (near_limit) begin
      foreach (lead[i]) txt.push_back(8'(lead[i]));
      txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(5, 9)));
      txt.push_back(dttf_pkg::CH_POINT);
      repeat ($urandom_range(5, 12))
        txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(7, 9)));
    end else begin
      repeat ($urandom_range(0, max_int))
        txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 1) begin
        txt.push_back(dttf_pkg::CH_POINT);
        repeat ($urandom_range(0, max_frac))
          txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    // occasional trailing junk stops the parse
    if ($urandom_range(0, 15) == 0) txt.push_back(8'($urandom_range(0, 255)));
    if (txt.size() == 0) txt.push_back(dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    send_text(txt);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result check against the oldest predicted number
  always @(posedge clk) begin
    parse_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_numbers.size() == 0) begin
        $error("unexpected result beat: value %0d", $signed(out_tdata));
        mismatches++;
      end else begin
        want = pending_numbers.pop_front();
        if (out_tdata !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser[0] !== want.invalid) begin
          $error("invalid: expected %0b, got %0b", want.invalid, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** decimal_text_to_fixed_point: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Signs, point handling, stop cases, invalid codes, text without digits
  task automatic test_directed();
    send_text('{dttf_pkg::CH_TAB, dttf_pkg::CH_MINUS, dttf_pkg::CH_ZERO + 8'd7});
    send_text('{dttf_pkg::CH_PLUS, dttf_pkg::CH_POINT, dttf_pkg::CH_ZERO + 8'd5});
    send_text('{dttf_pkg::CH_MINUS, dttf_pkg::CH_ZERO});                       // negative zero
    send_text('{dttf_pkg::CH_MINUS, dttf_pkg::CH_MINUS, dttf_pkg::CH_ZERO + 8'd1}); // second sign
    send_text('{dttf_pkg::CH_ZERO + 8'd3, dttf_pkg::CH_SPACE, dttf_pkg::CH_ZERO + 8'd4});
    send_text('{dttf_pkg::CH_ZERO + 8'd1, dttf_pkg::CH_POINT, dttf_pkg::CH_POINT}); // second point
    send_text('{CH_TOP});
    send_text('{dttf_pkg::CH_NINE, CH_NUL});                                   // NUL is invalid
    send_text('{dttf_pkg::CH_POINT});
    send_text('{dttf_pkg::CH_CR});
  endtask

  // Well-formed numbers, long integers and near-limit values for saturation
  task automatic test_random_numbers(input int target);
    while (chars_sent < target)
      send_number(12, 12, $urandom_range(0, 11) == 0);
  endtask

  // Random bytes, mostly allowed characters, random string ends
  task automatic test_noise(input int target);
    logic [7:0] c;
    logic       last;
    last = 1'b1;
    while (chars_sent < target) begin
      case ($urandom_range(0, 3))
        0:       c = 8'($urandom_range(0, 255));
        1:       c = dttf_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        2:       c = ($urandom_range(0, 1) == 1) ? dttf_pkg::CH_POINT : dttf_pkg::CH_SPACE;
        default: c = ($urandom_range(0, 1) == 1) ? dttf_pkg::CH_PLUS : dttf_pkg::CH_MINUS;
      endcase
      last = ($urandom_range(0, 5) == 0);
      send_char(c, last);
    end
    if (!last) send_char(dttf_pkg::CH_ZERO + 8'd1, 1'b1);
  endtask

  // Long receiver hold-off while short strings keep coming
  task automatic test_backpressure(input int target);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    while (chars_sent < target) send_number(2, 1, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate(input int target);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (chars_sent < target) send_number(10, 10, $urandom_range(0, 15) == 0);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    hold_req   = 1'b0;
    chars_sent = 0;
    mismatches = 0;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_numbers(1150);
    test_noise(1550);
    test_backpressure(1680);
    test_full_rate(1870);
    in_tvalid <= 1'b0;

    // drain, then allow for pipeline latency
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** decimal_text_to_fixed_point: PASSED **");
    end else begin
      $display("** decimal_text_to_fixed_point: FAILED **");
    end
    $finish;
  end

endmodule
